### sv/mae_pkg.sv
package mae_pkg;

	// Default longest address plus one (captures hold one byte less)
	localparam int ADDR_MAX_LEN_DEF = 64;

	// Character codes
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0a;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_COMMA   = 8'h2c;
	localparam logic [7:0] CH_LANGLE  = 8'h3c;
	localparam logic [7:0] CH_RANGLE  = 8'h3e;
	localparam logic [7:0] CH_ESC     = 8'h1b;
	localparam logic [7:0] ESC_END_LO = 8'h30;
	localparam logic [7:0] ESC_END_HI = 8'h7e;
	localparam logic [7:0] DEPTH_MAX  = 8'hff;

	// Address request from the scanner to the emit sequencer
	typedef struct packed {
		logic go;
		logic from_angle;
		logic quote_unmatched;
		logic comment_unclosed;
	} emit_req_t;

	// Byte that closes a capture
	function automatic logic is_delim(input logic [7:0] c);
		return (c == CH_NUL) || (c == CH_COMMA) || (c == CH_SPACE) || (c == CH_TAB) ||
		       (c == CH_LF) || (c == CH_RANGLE) || (c == CH_LPAREN);
	endfunction

	// Byte skipped between addresses
	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_COMMA) || (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
	endfunction

endpackage

### sv/mae_cap_ram.sv
module mae_cap_ram import mae_pkg::*; #(
	parameter int DEPTH = ADDR_MAX_LEN_DEF - 1,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// Write one captured byte
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/mae_scan.sv
module mae_scan import mae_pkg::*; #(
	parameter int ADDR_MAX_LEN = ADDR_MAX_LEN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  take,
	input  logic [7:0]                            text_byte,
	output logic                                  plain_we,
	output logic [$clog2(ADDR_MAX_LEN)-1:0]       plain_waddr,
	output logic [7:0]                            plain_wdata,
	output logic                                  angle_we,
	output logic [$clog2(ADDR_MAX_LEN)-1:0]       angle_waddr,
	output logic [7:0]                            angle_wdata,
	output emit_req_t                             req,
	output logic [$clog2(ADDR_MAX_LEN)-1:0]       req_len
);

	localparam int CAP   = ADDR_MAX_LEN - 1;
	localparam int LEN_W = $clog2(ADDR_MAX_LEN);

	// Scan modes
	localparam logic [2:0] M_TEXT      = 3'd0;
	localparam logic [2:0] M_QUOTE     = 3'd1;
	localparam logic [2:0] M_ESC_TEXT  = 3'd2;
	localparam logic [2:0] M_ESC_QUOTE = 3'd3;
	localparam logic [2:0] M_COMMENT   = 3'd4;
	localparam logic [2:0] M_ANGLE     = 3'd5;
	localparam logic [2:0] M_SKIP      = 3'd6;

	// Angle capture phases
	localparam logic [1:0] A_NONE  = 2'd0;
	localparam logic [1:0] A_BLANK = 2'd1;
	localparam logic [1:0] A_TAKE  = 2'd2;
	localparam logic [1:0] A_DONE  = 2'd3;

	logic [2:0]       mode_q, mode_n, mode_w;
	logic [LEN_W-1:0] plen_q, plen_n;
	logic             popen_q, popen_n;
	logic [LEN_W-1:0] alen_q, alen_n;
	logic [1:0]       aphase_q, aphase_n, aphase_w;
	logic [7:0]       depth_q, depth_n, depth_dec;
	logic             fstart_q, fstart_n;
	logic [7:0]       pf;
	logic             do_clear;

	assign plain_waddr = plen_q;
	assign plain_wdata = pf;
	assign angle_waddr = alen_q;
	assign angle_wdata = text_byte;
	assign req_len     = req.from_angle ? alen_q : plen_q;
	assign depth_dec   = (depth_q != 8'd0) ? depth_q - 8'd1 : 8'd0;

	// Mode seen by this byte: a skip ends at the first non-separator
	assign mode_w = (mode_q == M_SKIP) ? M_TEXT : mode_q;

	// Byte handed to the plain capture: escape bytes count as blanks
	assign pf = ((mode_w == M_ESC_TEXT) || (mode_w == M_ESC_QUOTE) ||
	             (((mode_w == M_TEXT) || (mode_w == M_QUOTE)) && (text_byte == CH_ESC)))
	            ? CH_SPACE : text_byte;

	// Leave the blank-skip phase on the first non-blank
	assign aphase_w = ((aphase_q == A_BLANK) && (text_byte != CH_SPACE) && (text_byte != CH_TAB))
	                  ? A_TAKE : aphase_q;

	// Next state for one accepted byte
	always_comb begin
		mode_n   = mode_q;
		plen_n   = plen_q;
		popen_n  = popen_q;
		alen_n   = alen_q;
		aphase_n = aphase_q;
		depth_n  = depth_q;
		fstart_n = fstart_q;
		plain_we = 1'b0;
		angle_we = 1'b0;
		req      = '0;
		do_clear = 1'b0;
		if (take) begin
			if (text_byte == CH_NUL) begin
				// End of field: flush the plain capture if an address began
				req.go               = (mode_q != M_SKIP) && fstart_q;
				req.quote_unmatched  = (mode_q == M_QUOTE) || (mode_q == M_ESC_QUOTE);
				req.comment_unclosed = (mode_q == M_COMMENT);
				do_clear             = 1'b1;
				mode_n               = M_TEXT;
			end else if (!((mode_q == M_SKIP) && is_sep(text_byte))) begin
				fstart_n = 1'b1;
				mode_n   = mode_w;
				// Plain capture
				if (popen_q) begin
					if (is_delim(pf)) begin
						popen_n = 1'b0;
					end else if (plen_q < LEN_W'(CAP)) begin
						plain_we = 1'b1;
						plen_n   = plen_q + 1'b1;
					end
				end
				// Angle capture
				if (mode_w == M_ANGLE) begin
					aphase_n = aphase_w;
					if (aphase_w == A_TAKE) begin
						if (is_delim(text_byte)) begin
							aphase_n = A_DONE;
						end else if (alen_q < LEN_W'(CAP)) begin
							angle_we = 1'b1;
							alen_n   = alen_q + 1'b1;
						end
					end
				end
				// Mode transitions
				case (mode_w)
					M_ESC_TEXT, M_ESC_QUOTE: begin
						if ((text_byte >= ESC_END_LO) && (text_byte <= ESC_END_HI)) begin
							mode_n = (mode_w == M_ESC_TEXT) ? M_TEXT : M_QUOTE;
						end
					end
					M_QUOTE: begin
						if (text_byte == CH_ESC) begin
							mode_n = M_ESC_QUOTE;
						end else if (text_byte == CH_DQUOTE) begin
							mode_n = M_TEXT;
						end
					end
					M_COMMENT: begin
						if (text_byte == CH_LPAREN) begin
							if (depth_q != DEPTH_MAX) begin
								depth_n = depth_q + 8'd1;
							end
						end else if (text_byte == CH_RPAREN) begin
							depth_n = depth_dec;
							if (depth_dec == 8'd0) begin
								mode_n = M_TEXT;
							end
						end
					end
					M_ANGLE: begin
						if (text_byte == CH_RANGLE) begin
							req.go         = 1'b1;
							req.from_angle = 1'b1;
							do_clear       = 1'b1;
							mode_n         = M_SKIP;
						end
					end
					default: begin
						if (text_byte == CH_ESC) begin
							mode_n = M_ESC_TEXT;
						end else if (text_byte == CH_LPAREN) begin
							depth_n = 8'd1;
							mode_n  = M_COMMENT;
						end else if (text_byte == CH_LANGLE) begin
							alen_n   = '0;
							aphase_n = A_BLANK;
							mode_n   = M_ANGLE;
						end else if (text_byte == CH_DQUOTE) begin
							mode_n = M_QUOTE;
						end else if ((text_byte == CH_COMMA) || (text_byte == CH_LF)) begin
							req.go   = 1'b1;
							do_clear = 1'b1;
							mode_n   = M_SKIP;
						end
					end
				endcase
			end
			// Drop the address state once it is handed off
			if (do_clear) begin
				plen_n   = '0;
				popen_n  = 1'b1;
				alen_n   = '0;
				aphase_n = A_NONE;
				depth_n  = 8'd0;
				fstart_n = 1'b0;
			end
		end
	end

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_TEXT;
			plen_q   <= '0;
			popen_q  <= 1'b1;
			alen_q   <= '0;
			aphase_q <= A_NONE;
			depth_q  <= 8'd0;
			fstart_q <= 1'b0;
		end else begin
			mode_q   <= mode_n;
			plen_q   <= plen_n;
			popen_q  <= popen_n;
			alen_q   <= alen_n;
			aphase_q <= aphase_n;
			depth_q  <= depth_n;
			fstart_q <= fstart_n;
		end
	end

endmodule

### sv/mae_emit.sv
module mae_emit import mae_pkg::*; #(
	parameter int ADDR_MAX_LEN = ADDR_MAX_LEN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  emit_req_t                             req,
	input  logic [$clog2(ADDR_MAX_LEN)-1:0]       req_len,
	output logic                                  busy,
	output logic                                  rd_en,
	output logic [((ADDR_MAX_LEN > 2) ? $clog2(ADDR_MAX_LEN-1) : 1)-1:0] rd_addr,
	input  logic [7:0]                            plain_rdata,
	input  logic [7:0]                            angle_rdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [7:0]                            m_tdata,
	output logic                                  m_tlast,
	output logic [3:0]                            m_tuser
);

	localparam int LEN_W = $clog2(ADDR_MAX_LEN);
	localparam int AW    = (ADDR_MAX_LEN > 2) ? $clog2(ADDR_MAX_LEN - 1) : 1;

	localparam logic [1:0] E_IDLE   = 2'd0;
	localparam logic [1:0] E_START  = 2'd1;
	localparam logic [1:0] E_STREAM = 2'd2;

	logic [1:0]       st_q, st_n;
	logic [LEN_W-1:0] idx_q, idx_n, idx_inc;
	logic [LEN_W-1:0] len_q;
	emit_req_t        req_q;
	logic             slot_free;
	logic             load, ld_last, ld_empty;
	logic [7:0]       ld_byte;
	logic             ov_q;
	logic [7:0]       odata_q;
	logic             olast_q;
	logic [3:0]       ouser_q;

	assign slot_free = !ov_q || m_tready;
	assign idx_inc   = idx_q + 1'b1;
	assign busy      = (st_q != E_IDLE);

	// Sequencer: one capture byte per cycle into the output register while it has room
	always_comb begin
		st_n     = st_q;
		idx_n    = idx_q;
		rd_en    = 1'b0;
		rd_addr  = idx_q[AW-1:0];
		load     = 1'b0;
		ld_byte  = 8'd0;
		ld_last  = 1'b0;
		ld_empty = 1'b0;
		unique case (st_q)
			E_IDLE: begin
				if (req.go) begin
					st_n = E_START;
				end
			end
			E_START: begin
				if (len_q == '0) begin
					if (slot_free) begin
						load     = 1'b1;
						ld_last  = 1'b1;
						ld_empty = 1'b1;
						st_n     = E_IDLE;
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = '0;
					idx_n   = '0;
					st_n    = E_STREAM;
				end
			end
			E_STREAM: begin
				if (slot_free) begin
					load    = 1'b1;
					ld_byte = req_q.from_angle ? angle_rdata : plain_rdata;
					ld_last = (idx_inc == len_q);
					if (ld_last) begin
						st_n = E_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_inc[AW-1:0];
						idx_n   = idx_inc;
					end
				end
			end
			default: begin
				st_n = E_IDLE;
			end
		endcase
	end

	// Sequencer state and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= E_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (load) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		idx_q <= idx_n;
		if ((st_q == E_IDLE) && req.go) begin
			len_q <= req_len;
			req_q <= req;
		end
		if (load) begin
			odata_q <= ld_byte;
			olast_q <= ld_last;
			ouser_q <= {req_q.comment_unclosed, req_q.quote_unmatched,
			            req_q.from_angle, ld_empty};
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = odata_q;
	assign m_tlast  = olast_q;
	assign m_tuser  = ouser_q;

endmodule

### sv/mail_address_extractor_unit.sv
// Channel  | Ports                          | Contents
// ---------+--------------------------------+----------------------------------------
// s (in)   | s_tvalid s_tready s_tdata[7:0] | text_byte, 0 ends the header field
// m (out)  | m_tvalid m_tready m_tdata[7:0] | addr_byte; m_tlast = addr_last
//          | m_tuser[3:0]                   | addr_empty, from_angle, quote_unmatched,
//          |                                | comment_unclosed
//
// A byte that ends no address is taken back to back.
// A byte that ends an address starts the emit sequencer, which reads the capture RAM
// one byte per cycle while the output register has room; s_tready is low meanwhile.
// A low m_tready stalls the run; the output register lets the next byte be taken
// while the last item of a run waits.
// Reset clears the scanner and sequencer; the capture RAMs are not cleared.
module mail_address_extractor_unit import mae_pkg::*; #(
	parameter int ADDR_MAX_LEN = ADDR_MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] addr_byte
	output logic       m_tlast,
	output logic [3:0] m_tuser    // [0] addr_empty [1] from_angle [2] quote_unmatched
	                              // [3] comment_unclosed
);

	localparam int CAP   = ADDR_MAX_LEN - 1;
	localparam int LEN_W = $clog2(ADDR_MAX_LEN);
	localparam int AW    = (ADDR_MAX_LEN > 2) ? $clog2(ADDR_MAX_LEN - 1) : 1;

	logic             take;
	logic             busy;
	logic             plain_we, angle_we;
	logic [LEN_W-1:0] plain_waddr, angle_waddr;
	logic [7:0]       plain_wdata, angle_wdata;
	logic [7:0]       plain_rdata, angle_rdata;
	emit_req_t        req;
	logic [LEN_W-1:0] req_len;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;

	// Take a byte only while no address is being sent
	assign s_tready = !busy;
	assign take     = s_tvalid && s_tready;

	mae_scan #(
		.ADDR_MAX_LEN(ADDR_MAX_LEN)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.text_byte   (s_tdata),
		.plain_we    (plain_we),
		.plain_waddr (plain_waddr),
		.plain_wdata (plain_wdata),
		.angle_we    (angle_we),
		.angle_waddr (angle_waddr),
		.angle_wdata (angle_wdata),
		.req         (req),
		.req_len     (req_len)
	);

	mae_cap_ram #(
		.DEPTH(CAP),
		.AW   (AW)
	) u_plain_ram (
		.clk   (clk),
		.we    (plain_we),
		.waddr (plain_waddr[AW-1:0]),
		.wdata (plain_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (plain_rdata)
	);

	mae_cap_ram #(
		.DEPTH(CAP),
		.AW   (AW)
	) u_angle_ram (
		.clk   (clk),
		.we    (angle_we),
		.waddr (angle_waddr[AW-1:0]),
		.wdata (angle_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (angle_rdata)
	);

	mae_emit #(
		.ADDR_MAX_LEN(ADDR_MAX_LEN)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.req_len     (req_len),
		.busy        (busy),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.plain_rdata (plain_rdata),
		.angle_rdata (angle_rdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser)
	);

endmodule

### sv/mae_checker.sv
module mae_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [3:0] m_tuser
);

	// Hold intake while a run is still being sent
	a_busy_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("byte requests taken in the middle of an address run");

	// An empty address is a single zero item
	a_empty_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 8'd0))
		else $error("empty address is not a single zero item");

	// An angle address never carries end-of-field warnings
	a_angle_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[2] && !m_tuser[3])
		else $error("angle address carries warning flags");

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
		$stable(m_tuser))
		else $error("stalled result request changed");

endmodule

bind mail_address_extractor_unit mae_checker u_mae_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mae_pkg::*;

	localparam int CAP         = ADDR_MAX_LEN_DEF - 1;
	localparam int RANDOM_LEN  = 380;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 150;
	localparam int HOLDOFF_LEN = 150;
	localparam int PRINT_MAX   = 20;

	typedef enum logic [2:0] {
		SCAN_TEXT, SCAN_QUOTE, SCAN_ESC_TEXT, SCAN_ESC_QUOTE,
		SCAN_COMMENT, SCAN_ANGLE, SCAN_SKIP
	} scan_mode_t;

	typedef enum logic [1:0] {ANG_NONE, ANG_SKIP, ANG_TAKE, ANG_DONE} angle_phase_t;

	// One address byte as it leaves the block
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       empty;
		logic       angle;
		logic       quote;
		logic       comment;
	} addr_item_t;

	logic       clk;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;   // [7:0] text_byte
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [7:0] addr_byte
	logic       m_tlast;
	logic [3:0] m_tuser;            // [0] addr_empty [1] from_angle [2] quote_unmatched
	                                // [3] comment_unclosed

	mail_address_extractor_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	logic [7:0] text_pending[$];
	addr_item_t addr_expect[$];

	logic in_fire = 1'b0;
	int   stall_cycles = 0;
	int   accepted_text = 0;
	int   results_seen = 0;
	int   addresses_seen = 0;
	int   errors = 0;
	int   holdoff_at = 0;
	int   holdoff_left = 0;
	bit   holdoff_done = 0;
	logic quiet;

	// Predictor state
	logic [7:0]   plain_buf[CAP];
	int           plain_len;
	bit           plain_on;
	logic [7:0]   angle_buf[CAP];
	int           angle_len;
	angle_phase_t angle_ph;
	scan_mode_t   scan;
	logic [7:0]   depth;
	bit           started;

	// Stretch with no idling on either side, after the long hold-off
	assign quiet = (accepted_text >= holdoff_at + 120) && (accepted_text < holdoff_at + 300);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------ predictor

	function automatic bit text_break(input logic [7:0] c);
		return c == CH_NUL || c == CH_COMMA || c == CH_SPACE || c == CH_TAB ||
		       c == CH_LF || c == CH_RANGLE || c == CH_LPAREN;
	endfunction

	task automatic plain_take(input logic [7:0] c);
		if (!plain_on)
			return;
		if (text_break(c))
			plain_on = 0;
		else if (plain_len < CAP) begin
			plain_buf[plain_len] = c;
			plain_len++;
		end
	endtask

	task automatic angle_take(input logic [7:0] c);
		if (angle_ph == ANG_SKIP) begin
			if (c == CH_SPACE || c == CH_TAB)
				return;
			angle_ph = ANG_TAKE;
		end
		if (angle_ph == ANG_TAKE) begin
			if (text_break(c))
				angle_ph = ANG_DONE;
			else if (angle_len < CAP) begin
				angle_buf[angle_len] = c;
				angle_len++;
			end
		end
	endtask

	task automatic clear_address();
		plain_len = 0;
		plain_on  = 1;
		angle_len = 0;
		angle_ph  = ANG_NONE;
		depth     = 8'd0;
		started   = 0;
	endtask

	// Queue one address run from either capture
	task automatic queue_address(input bit angle, input bit quote, input bit comment);
		int n;
		addr_item_t it;
		n = angle ? angle_len : plain_len;
		it.angle   = angle;
		it.quote   = quote;
		it.comment = comment;
		if (n == 0) begin
			it.data  = 8'h00;
			it.last  = 1'b1;
			it.empty = 1'b1;
			addr_expect.push_back(it);
		end else begin
			for (int k = 0; k < n; k++) begin
				it.data  = angle ? angle_buf[k] : plain_buf[k];
				it.last  = (k == n - 1);
				it.empty = 1'b0;
				addr_expect.push_back(it);
			end
		end
	endtask

	// Advance the scanner by one text byte
	task automatic predict_text(input logic [7:0] b);
		if (b == CH_NUL) begin
			if (scan != SCAN_SKIP && started)
				queue_address(0, scan == SCAN_QUOTE || scan == SCAN_ESC_QUOTE,
				              scan == SCAN_COMMENT);
			clear_address();
			scan = SCAN_TEXT;
			return;
		end
		if (scan == SCAN_SKIP) begin
			if (b == CH_COMMA || b == CH_SPACE || b == CH_TAB || b == CH_LF)
				return;
			scan = SCAN_TEXT;
		end
		if (!started) begin
			clear_address();
			started = 1;
		end
		case (scan)
			SCAN_ESC_TEXT, SCAN_ESC_QUOTE: begin
				plain_take(CH_SPACE);
				if (b >= ESC_END_LO && b <= ESC_END_HI)
					scan = (scan == SCAN_ESC_TEXT) ? SCAN_TEXT : SCAN_QUOTE;
			end
			SCAN_QUOTE: begin
				if (b == CH_ESC) begin
					plain_take(CH_SPACE);
					scan = SCAN_ESC_QUOTE;
				end else begin
					plain_take(b);
					if (b == CH_DQUOTE)
						scan = SCAN_TEXT;
				end
			end
			SCAN_COMMENT: begin
				plain_take(b);
				if (b == CH_LPAREN) begin
					if (depth < DEPTH_MAX)
						depth++;
				end else if (b == CH_RPAREN) begin
					if (depth > 0)
						depth--;
					if (depth == 0)
						scan = SCAN_TEXT;
				end
			end
			SCAN_ANGLE: begin
				plain_take(b);
				angle_take(b);
				if (b == CH_RANGLE) begin
					queue_address(1, 0, 0);
					clear_address();
					scan = SCAN_SKIP;
				end
			end
			default: begin
				if (b == CH_ESC) begin
					plain_take(CH_SPACE);
					scan = SCAN_ESC_TEXT;
				end else begin
					plain_take(b);
					if (b == CH_LPAREN) begin
						depth = 8'd1;
						scan  = SCAN_COMMENT;
					end else if (b == CH_LANGLE) begin
						angle_len = 0;
						angle_ph  = ANG_SKIP;
						scan      = SCAN_ANGLE;
					end else if (b == CH_DQUOTE) begin
						scan = SCAN_QUOTE;
					end else if (b == CH_COMMA || b == CH_LF) begin
						queue_address(0, 0, 0);
						clear_address();
						scan = SCAN_SKIP;
					end
				end
			end
		endcase
	endtask

	// ------------------------------------------------------------------ stimulus

	task automatic push_byte(input logic [7:0] b);
		text_pending.push_back(b);
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_pending.push_back(s[i]);
	endtask

	task automatic push_word(input int len);
		string chars;
		chars = "abcdefghijklmnopqrstuvwxyz0123456789.-_+";
		repeat (len)
			push_byte(chars[$urandom_range(0, chars.len() - 1)]);
	endtask

	task automatic push_mailbox(input int name_len);
		push_word(name_len);
		push_str("@");
		push_word($urandom_range(1, 6));
		push_str(".org");
	endtask

	task automatic push_escape();
		push_byte(CH_ESC);
		repeat ($urandom_range(0, 2))
			push_byte(8'($urandom_range(8'h20, 8'h2f)));
		push_byte(8'($urandom_range(ESC_END_LO, ESC_END_HI)));
	endtask

	// One address in one of the usual header shapes, or a run of noise bytes
	task automatic push_address();
		case ($urandom_range(0, 11))
			0, 1, 2: push_mailbox($urandom_range(1, 8));
			3: begin
				push_str("\"");
				push_word($urandom_range(1, 6));
				push_str("\" <");
				push_mailbox($urandom_range(1, 8));
				push_str(">");
			end
			4: begin
				push_word($urandom_range(1, 6));
				push_str(" <");
				repeat ($urandom_range(0, 3))
					push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
				push_mailbox($urandom_range(1, 8));
				push_str($urandom_range(0, 1) ? ">" : " >");
			end
			5: begin
				push_mailbox($urandom_range(1, 8));
				push_str(" (");
				push_word($urandom_range(1, 4));
				push_str("(");
				push_word($urandom_range(1, 4));
				push_str("))");
			end
			6: begin
				if ($urandom_range(0, 1))
					push_escape();
				push_mailbox($urandom_range(1, 8));
				if ($urandom_range(0, 1))
					push_escape();
			end
			7: begin
				push_str("\"");
				push_word($urandom_range(1, 4));
				push_escape();
				push_word($urandom_range(1, 4));
				push_str("\" <");
				push_mailbox($urandom_range(1, 8));
				push_str(">");
			end
			8: begin
				repeat ($urandom_range(1, 4))
					push_byte(8'($urandom_range(1, 255)));
			end
			9: begin
				if ($urandom_range(0, 1))
					push_mailbox($urandom_range(66, 75));
				else begin
					push_str("<");
					push_mailbox($urandom_range(66, 75));
					push_str(">");
				end
			end
			default: begin
				push_mailbox($urandom_range(1, 8));
				repeat ($urandom_range(1, 3))
					push_byte(8'($urandom_range(1, 255)));
			end
		endcase
	endtask

	// One header field: a list of addresses, possibly broken at the end
	task automatic push_field();
		int n_addr;
		n_addr = $urandom_range(1, 4);
		if ($urandom_range(0, 9) == 0)
			push_str($urandom_range(0, 1) ? " " : ",");
		for (int i = 0; i < n_addr; i++) begin
			if (i > 0)
				case ($urandom_range(0, 3))
					0: push_str(",");
					1: push_str(", ");
					2: push_str("\n ");
					default: push_str(",\t");
				endcase
			push_address();
		end
		case ($urandom_range(0, 9))
			0: push_str(" \"open");
			1: push_str(" (open");
			2: push_str(" <half");
			3: push_str(", ");
			default: ;
		endcase
		push_byte(CH_NUL);
	endtask

	// ------------------------------------------------------------------ driver and monitor

	// Offer the next text byte; hold it until taken
	always @(negedge clk) begin : text_driver
		if (in_fire)
			void'(text_pending.pop_front());
		if (!s_tvalid || in_fire) begin
			if (arst_n && text_pending.size() != 0 && (quiet || $urandom_range(0, 99) >= 6)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= text_pending[0];
			end else
				s_tvalid <= 1'b0;
		end
	end

	// Accept results, with one long hold-off to back up the block
	always @(negedge clk) begin : result_receiver
		if (holdoff_left != 0) begin
			holdoff_left--;
			m_tready <= 1'b0;
		end else if (!holdoff_done && holdoff_at != 0 && accepted_text >= holdoff_at) begin
			holdoff_done = 1;
			holdoff_left = HOLDOFF_LEN - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= quiet || $urandom_range(0, 99) >= 6;
	end

	function automatic string item_text(input addr_item_t it);
		return $sformatf("byte=%h last=%b empty=%b angle=%b quote=%b comment=%b",
		                 it.data, it.last, it.empty, it.angle, it.quote, it.comment);
	endfunction

	task automatic report_mismatch(input string msg);
		if (errors < PRINT_MAX)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// Check results against the oldest expectation, then predict new requests
	always @(posedge clk) begin : stream_monitor
		addr_item_t got;
		addr_item_t want;
		in_fire <= s_tvalid && s_tready;
		stall_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ? 0 : stall_cycles + 1;
		if (m_tvalid && m_tready) begin
			got = {m_tdata, m_tlast, m_tuser[0], m_tuser[1], m_tuser[2], m_tuser[3]};
			results_seen++;
			if (m_tlast)
				addresses_seen++;
			if (addr_expect.size() == 0)
				report_mismatch({"result with nothing expected: ", item_text(got)});
			else begin
				want = addr_expect.pop_front();
				if (got !== want)
					report_mismatch({"got ", item_text(got), " want ", item_text(want)});
			end
		end
		if (s_tvalid && s_tready) begin
			predict_text(s_tdata);
			accepted_text++;
		end
	end

	// Stop a run that makes no progress
	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("TIMEOUT: no request moved for %0d cycles", STALL_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------ sequence

	initial begin : run_sequence
		int random_start;
		clear_address();
		scan = SCAN_TEXT;

		// Directed: empty field, comma list, leading blank, open quote,
		// open comment, angle with trailing text, high byte cut by an escape
		push_byte(CH_NUL);
		push_str("a@b,");
		push_byte(CH_NUL);
		push_str(" ");
		push_byte(CH_NUL);
		push_str("\"q");
		push_byte(CH_NUL);
		push_str("(c");
		push_byte(CH_NUL);
		push_str("<x> y");
		push_byte(CH_NUL);
		push_byte(8'hff);
		push_byte(CH_ESC);
		push_str("Bc");
		push_byte(CH_NUL);

		// Nested comment, closed one level at a time
		push_str("x");
		repeat (5) push_byte(CH_LPAREN);
		repeat (5) push_byte(CH_RPAREN);
		push_str(",");
		push_byte(CH_NUL);

		random_start = text_pending.size();
		holdoff_at   = random_start + 100;
		while (text_pending.size() < random_start + RANDOM_LEN)
			push_field();

		// Drain everything, then allow for a late stray result
		while (text_pending.size() != 0 || addr_expect.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (addr_expect.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", addr_expect.size()));

		$display("Scanned %0d header bytes (plain, angle, quoted, comment, escape, noise)",
		         accepted_text);
		$display("Checked %0d address bytes in %0d addresses, %0d mismatches",
		         results_seen, addresses_seen, errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
